>>> rtl/core/tank_level_switch_qualifier_core_defines.svh
// Assertion macros for the tank level switch qualifier core.
// Included by the top level; the macros expect clk and arst_n in scope.
`ifndef TANK_LEVEL_SWITCH_QUALIFIER_CORE_DEFINES_SVH
`define TANK_LEVEL_SWITCH_QUALIFIER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TLSQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TLSQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/tlsq_pkg.sv
// Shared types and constants for the tank level switch qualifier core.
// No dependencies.
`timescale 1ns / 1ps

package tlsq_pkg;

	localparam int QUALIFY_WIDTH   = 8;
	localparam int MODE_WIDTH      = 2;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = 8;
	localparam int SECONDS_WIDTH   = 32;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUALIFY_SECONDS = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ALERT_MODE      = 2'd1;

	localparam logic [QUALIFY_WIDTH-1:0] QUALIFY_SECONDS_RESET = 8'd15;
	localparam logic [MODE_WIDTH-1:0]    ALERT_MODE_RESET      = 2'd3;

	localparam int MODE_HIGH_ALERT_BIT = 0;
	localparam int MODE_LOW_ALERT_BIT  = 1;

	typedef struct packed {
		logic                     low_switch_level;
		logic                     high_switch_level;
		logic [SECONDS_WIDTH-1:0] seconds_now;
	} sample_t;

	typedef struct packed {
		logic low_level_latched;
		logic high_level_latched;
		logic low_alert;
		logic low_recovered;
		logic high_alert;
	} result_t;

	typedef struct packed {
		logic latched;
		logic alert;
		logic recovered;
	} low_res_t;

	typedef struct packed {
		logic latched;
		logic alert;
	} high_res_t;

endpackage

>>> rtl/core/tlsq_low_switch.sv
// Low level switch qualifier: hold timer and last qualified direction.
// Depends on tlsq_pkg.
`timescale 1ns / 1ps

module tlsq_low_switch #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                pin,
	input  logic [TIME_WIDTH-1:0]               now,
	input  logic [tlsq_pkg::QUALIFY_WIDTH-1:0]  qualify_seconds,
	input  logic                                alert_enable,
	output tlsq_pkg::low_res_t                  res
);
	import tlsq_pkg::*;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_LOW  = 2'd1,
		DIR_HIGH = 2'd2
	} dir_t;

	logic                  pending_q;
	logic [TIME_WIDTH-1:0] start_q;
	dir_t                  last_dir_q;
	logic                  latched_q;

	dir_t                  want;
	logic [TIME_WIDTH-1:0] elapsed;
	logic                  expired;

	assign want    = pin ? DIR_HIGH : DIR_LOW;
	assign elapsed = now - start_q;
	assign expired = elapsed > TIME_WIDTH'(qualify_seconds);

	always_comb begin
		res.latched   = latched_q;
		res.alert     = 1'b0;
		res.recovered = 1'b0;
		if (pending_q && expired) begin
			res.latched   = !pin;
			res.alert     = !pin && alert_enable;
			res.recovered = pin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= 1'b0;
			start_q    <= '0;
			last_dir_q <= DIR_NONE;
			latched_q  <= 1'b0;
		end else if (en) begin
			if (!pending_q) begin
				if (last_dir_q != want) begin
					start_q   <= now;
					pending_q <= 1'b1;
				end
			end else if (expired) begin
				pending_q  <= 1'b0;
				start_q    <= '0;
				last_dir_q <= want;
				latched_q  <= !pin;
			end
		end
	end

endmodule

>>> rtl/core/tlsq_high_switch.sv
// High level switch qualifier: latches on a held low pin, releases on a held high pin.
// Depends on tlsq_pkg.
`timescale 1ns / 1ps

module tlsq_high_switch #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                pin,
	input  logic [TIME_WIDTH-1:0]               now,
	input  logic [tlsq_pkg::QUALIFY_WIDTH-1:0]  qualify_seconds,
	input  logic                                alert_enable,
	output tlsq_pkg::high_res_t                 res
);
	import tlsq_pkg::*;

	logic                  pending_q;
	logic [TIME_WIDTH-1:0] start_q;
	logic                  latched_q;

	logic                  can_move;
	logic [TIME_WIDTH-1:0] elapsed;
	logic                  expired;
	logic                  qualify;

	assign can_move = pin ? latched_q : !latched_q;
	assign elapsed  = now - start_q;
	assign expired  = elapsed > TIME_WIDTH'(qualify_seconds);
	assign qualify  = can_move && pending_q && expired;

	always_comb begin
		res.latched = latched_q;
		res.alert   = 1'b0;
		if (qualify) begin
			res.latched = !pin;
			res.alert   = !pin && alert_enable;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			start_q   <= '0;
			latched_q <= 1'b0;
		end else if (en && can_move) begin
			if (!pending_q) begin
				start_q   <= now;
				pending_q <= 1'b1;
			end else if (expired) begin
				pending_q <= 1'b0;
				start_q   <= '0;
				latched_q <= !pin;
			end
		end
	end

endmodule

>>> rtl/core/tank_level_switch_qualifier_core.sv
// A sample waits in the sample register while result_stall holds the result register.
// Throughput: otherwise one sample per cycle; the sample and result registers each hold one item.
// Each switch does one subtract and compare per item between those two registers.
// Reset clears the valid flags and switch state, sets qualify_seconds to 15 and alert_mode to 3.
// Top level of the tank level switch qualifier; depends on tlsq_pkg, tlsq_low_switch,
// tlsq_high_switch and tank_level_switch_qualifier_core_defines.svh.
`timescale 1ns / 1ps
`include "tank_level_switch_qualifier_core_defines.svh"

module tank_level_switch_qualifier_core #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_stall,
	input  tlsq_pkg::sample_t                     sample,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output tlsq_pkg::result_t                     result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tlsq_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [tlsq_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
	import tlsq_pkg::*;

	logic [QUALIFY_WIDTH-1:0] qualify_seconds_q;
	logic [MODE_WIDTH-1:0]    alert_mode_q;

	logic    valid_s1;
	sample_t sample_s1;
	logic    result_valid_q;
	result_t result_q;

	logic                  advance;
	logic                  step;
	logic [TIME_WIDTH-1:0] now;
	low_res_t              low_res;
	high_res_t             high_res;

	assign cfg_ready    = 1'b1;
	assign advance      = !result_valid_q || !result_stall;
	assign sample_stall = valid_s1 && !advance;
	assign step         = valid_s1 && advance;
	assign now          = TIME_WIDTH'(sample_s1.seconds_now);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qualify_seconds_q <= QUALIFY_SECONDS_RESET;
			alert_mode_q      <= ALERT_MODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_QUALIFY_SECONDS: qualify_seconds_q <= cfg_data[QUALIFY_WIDTH-1:0];
				REG_ALERT_MODE:      alert_mode_q      <= cfg_data[MODE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
	end

	tlsq_low_switch #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_low (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (step),
		.pin            (sample_s1.low_switch_level),
		.now            (now),
		.qualify_seconds(qualify_seconds_q),
		.alert_enable   (alert_mode_q[MODE_LOW_ALERT_BIT]),
		.res            (low_res)
	);

	tlsq_high_switch #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_high (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (step),
		.pin            (sample_s1.high_switch_level),
		.now            (now),
		.qualify_seconds(qualify_seconds_q),
		.alert_enable   (alert_mode_q[MODE_HIGH_ALERT_BIT]),
		.res            (high_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q.low_level_latched  <= low_res.latched;
			result_q.high_level_latched <= high_res.latched;
			result_q.low_alert          <= low_res.alert;
			result_q.low_recovered      <= low_res.recovered;
			result_q.high_alert         <= high_res.alert;
		end
	end

	`TLSQ_ASSERT_IMP(a_stall_only_when_blocked, sample_stall, valid_s1 && result_valid_q && result_stall, "sample stalled without a blocked item")
	`TLSQ_ASSERT_NXT(a_blocked_item_kept, valid_s1 && !advance, valid_s1, "blocked item lost from the sample register")
	`TLSQ_ASSERT_NXT(a_step_gives_result, step, result_valid, "processed item did not reach the result register")

endmodule
